/* rtl/core/hsl_pkg.sv */
`timescale 1ns / 1ps

package hsl_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 10;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutDataW = 24;

  localparam logic [CodeW-1:0] CodeMinReset = 10'd100;
  localparam logic [CodeW-1:0] CodeMaxReset = 10'd599;
  localparam logic [CodeW-1:0] CodeSat      = 10'd1000;

  localparam logic [ByteW-1:0] ByteSp  = 8'h20;
  localparam logic [ByteW-1:0] ByteHt  = 8'h09;
  localparam logic [ByteW-1:0] ByteCr  = 8'h0D;
  localparam logic [ByteW-1:0] ByteLf  = 8'h0A;
  localparam logic [ByteW-1:0] ByteDel = 8'h7F;
  localparam logic [ByteW-1:0] Byte0   = 8'h30;
  localparam logic [ByteW-1:0] Byte9   = 8'h39;

  localparam logic [CfgIdxW-1:0] CfgCodeMin = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeMax = 2'd1;

  typedef enum logic [2:0] {
    PH_PROTOCOL = 3'd0,
    PH_CODE     = 3'd1,
    PH_REASON   = 3'd2,
    PH_LF       = 3'd3,
    PH_DONE     = 3'd4,
    PH_ERROR    = 3'd5
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_PROTO   = 3'd0,
    KIND_REASON  = 3'd1,
    KIND_DELIM   = 3'd2,
    KIND_LINE    = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_CODE  = 3'd1,
    ERR_NON_DIGIT = 3'd2,
    ERR_CTRL_CHAR = 3'd3,
    ERR_NO_LF     = 3'd4
  } err_e;

  typedef struct packed {
    phase_e           phase;
    logic [CodeW-1:0] code_value;
    logic             have_digit;
    err_e             last_error;
  } state_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] byte_out;
    logic [CodeW-1:0] status_code;
    err_e             error_code;
  } result_t;

endpackage

/* rtl/core/hsl_step.sv */
`timescale 1ns / 1ps

module hsl_step (
  input  hsl_pkg::state_t               state_i,
  input  logic [hsl_pkg::ByteW-1:0]     byte_i,
  input  logic [hsl_pkg::CodeW-1:0]     code_min_i,
  input  logic [hsl_pkg::CodeW-1:0]     code_max_i,
  output hsl_pkg::state_t               state_o,
  output hsl_pkg::result_t              result_o
);

  logic [13:0]              acc_wide;
  logic [hsl_pkg::CodeW-1:0] acc_sat;
  logic                     is_digit;
  logic                     code_ok;
  logic                     reason_ok;
  hsl_pkg::kind_e           kind;
  logic [hsl_pkg::ByteW-1:0] pass;
  hsl_pkg::state_t          nxt;

  // value * 10 + digit, held at the saturation value
  assign acc_wide = {1'b0, state_i.code_value, 3'b000}
                  + {3'b000, state_i.code_value, 1'b0}
                  + {10'd0, byte_i[3:0]};
  assign acc_sat  = (acc_wide > {4'd0, hsl_pkg::CodeSat}) ? hsl_pkg::CodeSat
                                                         : acc_wide[hsl_pkg::CodeW-1:0];
  assign is_digit = (byte_i >= hsl_pkg::Byte0) && (byte_i <= hsl_pkg::Byte9);
  assign code_ok  = state_i.have_digit && (state_i.code_value >= code_min_i)
                  && (state_i.code_value <= code_max_i);
  assign reason_ok = (byte_i == hsl_pkg::ByteHt)
                   || ((byte_i >= hsl_pkg::ByteSp) && (byte_i != hsl_pkg::ByteDel));

  // next state
  always_comb begin
    nxt = state_i;
    case (state_i.phase)
      hsl_pkg::PH_PROTOCOL: begin
        if (byte_i == hsl_pkg::ByteSp) begin
          nxt.phase = hsl_pkg::PH_CODE;
        end
      end
      hsl_pkg::PH_CODE: begin
        if (byte_i == hsl_pkg::ByteSp) begin
          if (code_ok) begin
            nxt.phase = hsl_pkg::PH_REASON;
          end else begin
            nxt.phase      = hsl_pkg::PH_ERROR;
            nxt.last_error = hsl_pkg::ERR_BAD_CODE;
          end
        end else if (byte_i == hsl_pkg::ByteCr) begin
          nxt.phase = hsl_pkg::PH_LF;
        end else if (is_digit) begin
          nxt.code_value = acc_sat;
          nxt.have_digit = 1'b1;
        end else begin
          nxt.phase      = hsl_pkg::PH_ERROR;
          nxt.last_error = hsl_pkg::ERR_NON_DIGIT;
        end
      end
      hsl_pkg::PH_REASON: begin
        if (byte_i == hsl_pkg::ByteCr) begin
          nxt.phase = hsl_pkg::PH_LF;
        end else if (!reason_ok) begin
          nxt.phase      = hsl_pkg::PH_ERROR;
          nxt.last_error = hsl_pkg::ERR_CTRL_CHAR;
        end
      end
      hsl_pkg::PH_LF: begin
        if (byte_i == hsl_pkg::ByteLf) begin
          nxt.phase = hsl_pkg::PH_DONE;
        end else begin
          nxt.phase      = hsl_pkg::PH_ERROR;
          nxt.last_error = hsl_pkg::ERR_NO_LF;
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  // result kind and pass-through byte
  always_comb begin
    kind = hsl_pkg::KIND_IGNORED;
    pass = '0;
    case (state_i.phase)
      hsl_pkg::PH_PROTOCOL: begin
        if (byte_i == hsl_pkg::ByteSp) begin
          kind = hsl_pkg::KIND_DELIM;
        end else begin
          kind = hsl_pkg::KIND_PROTO;
          pass = byte_i;
        end
      end
      hsl_pkg::PH_CODE: begin
        if (byte_i == hsl_pkg::ByteSp) begin
          if (code_ok) begin
            kind = hsl_pkg::KIND_DELIM;
          end else begin
            kind = hsl_pkg::KIND_ERROR;
          end
        end else if ((byte_i == hsl_pkg::ByteCr) || is_digit) begin
          kind = hsl_pkg::KIND_DELIM;
        end else begin
          kind = hsl_pkg::KIND_ERROR;
        end
      end
      hsl_pkg::PH_REASON: begin
        if (byte_i == hsl_pkg::ByteCr) begin
          kind = hsl_pkg::KIND_DELIM;
        end else if (reason_ok) begin
          kind = hsl_pkg::KIND_REASON;
          pass = byte_i;
        end else begin
          kind = hsl_pkg::KIND_ERROR;
        end
      end
      hsl_pkg::PH_LF: begin
        if (byte_i == hsl_pkg::ByteLf) begin
          kind = hsl_pkg::KIND_LINE;
        end else begin
          kind = hsl_pkg::KIND_ERROR;
        end
      end
      default: begin
        kind = hsl_pkg::KIND_IGNORED;
      end
    endcase
  end

  assign state_o              = nxt;
  assign result_o.kind        = kind;
  assign result_o.byte_out    = pass;
  assign result_o.status_code = nxt.code_value;
  assign result_o.error_code  = nxt.last_error;

endmodule

/* rtl/core/http_status_line_parser_core.sv */
`timescale 1ns / 1ps

// HTTP response status line parser.
// Slave stream: one received byte per item in s_axis_tdata.
// Master stream: one result per byte; s_axis item -> m_axis item, in order.
//   m_axis_tuser holds the result kind (protocol, reason, delimiter, line
//   complete, error, ignored); m_axis_tdata holds the byte, the status code
//   accumulated so far and the sticky error code.
// Config port: cfg_we_i writes cfg_wdata_i to code_min (index 0) or code_max
//   (index 1); other indexes are dropped. Write only while the block is idle.
// Path: an accepted byte goes into the input register; the parse step then
//   writes its result into the result register, which drives m_axis_tvalid.
// Throughput: one item per cycle while m_axis_tready is high; the parse
//   step between the two registers is a single pass over the byte and the state.
// Reset: parser returns to the protocol phase, code cleared, bounds 100..599,
//   both stages empty.
// Stall: while m_axis_tready is low the result register holds, the input
//   register still takes one item, then s_axis_tready drops.

module http_status_line_parser_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hsl_pkg::ByteW-1:0]       s_axis_tdata,   // [7:0] byte_value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] byte_out, [17:8] status_code, [20:18] error_code, [23:21] zero
  output logic [hsl_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic [hsl_pkg::KindW-1:0]       m_axis_tuser,   // [2:0] kind
  input  logic                            cfg_we_i,
  input  logic [hsl_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [hsl_pkg::CodeW-1:0]       cfg_wdata_i
);

  logic                        in_valid_q;
  logic [hsl_pkg::ByteW-1:0]   in_byte_q;
  logic                        out_valid_q;
  hsl_pkg::result_t            out_res_q;
  hsl_pkg::state_t             st_q;
  hsl_pkg::state_t             st_d;
  hsl_pkg::result_t            res_d;
  logic [hsl_pkg::CodeW-1:0]   code_min_q;
  logic [hsl_pkg::CodeW-1:0]   code_max_q;
  logic                        out_free;
  logic                        advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  hsl_step u_step (
    .state_i   (st_q),
    .byte_i    (in_byte_q),
    .code_min_i(code_min_q),
    .code_max_i(code_max_q),
    .state_o   (st_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_min_q <= hsl_pkg::CodeMinReset;
      code_max_q <= hsl_pkg::CodeMaxReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hsl_pkg::CfgCodeMin: code_min_q <= cfg_wdata_i;
        hsl_pkg::CfgCodeMax: code_max_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: hsl_pkg::PH_PROTOCOL, code_value: '0,
                       have_digit: 1'b0, last_error: hsl_pkg::ERR_NONE};
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tdata  = {3'b000, out_res_q.error_code, out_res_q.status_code,
                          out_res_q.byte_out};

endmodule

/* rtl/core/hsl_checker.sv */
`timescale 1ns / 1ps

module hsl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hsl_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [hsl_pkg::KindW-1:0]     m_axis_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // an error result always carries a non-zero error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == hsl_pkg::KIND_ERROR) |->
      (m_axis_tdata[20:18] != hsl_pkg::ERR_NONE))
    else $error("error result without error code");

  // only protocol and reason results pass the byte through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != hsl_pkg::KIND_PROTO)
      && (m_axis_tuser != hsl_pkg::KIND_REASON) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("byte passed on a non pass-through result");

  // the status code never exceeds the saturation value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:8] <= hsl_pkg::CodeSat))
    else $error("status code above saturation");

endmodule

bind http_status_line_parser_core hsl_checker u_hsl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import hsl_pkg::*;

  // no register sits at this index; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CodeW-1:0]    cfg_wdata_i;

  http_status_line_parser_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Tracks the parse of the status line and holds the results still owed.
  class status_line_tracker;
    logic [CodeW-1:0] code_min   = CodeMinReset;
    logic [CodeW-1:0] code_max   = CodeMaxReset;
    phase_e           phase      = PH_PROTOCOL;
    logic [CodeW-1:0] code_value = '0;
    logic             have_digit = 1'b0;
    err_e             last_error = ERR_NONE;
    result_t          pending_results[$];
    int               mismatches = 0;

    function void set_bound(logic [CfgIdxW-1:0] idx, logic [CodeW-1:0] val);
      if (idx == CfgCodeMin) code_min = val;
      else if (idx == CfgCodeMax) code_max = val;
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      result_t     r;
      int unsigned acc;
      r.kind     = KIND_IGNORED;
      r.byte_out = '0;
      case (phase)
        PH_PROTOCOL: begin
          if (b == ByteSp) begin
            r.kind = KIND_DELIM;
            phase  = PH_CODE;
          end else begin
            r.kind     = KIND_PROTO;
            r.byte_out = b;
          end
        end
        PH_CODE: begin
          if (b == ByteSp) begin
            if (!have_digit || code_value < code_min || code_value > code_max) begin
              r.kind     = KIND_ERROR;
              last_error = ERR_BAD_CODE;
              phase      = PH_ERROR;
            end else begin
              r.kind = KIND_DELIM;
              phase  = PH_REASON;
            end
          end else if (b == ByteCr) begin
            r.kind = KIND_DELIM;
            phase  = PH_LF;
          end else if (b >= Byte0 && b <= Byte9) begin
            acc        = code_value * 10 + (b - Byte0);
            code_value = (acc > CodeSat) ? CodeSat : CodeW'(acc);
            have_digit = 1'b1;
            r.kind     = KIND_DELIM;
          end else begin
            r.kind     = KIND_ERROR;
            last_error = ERR_NON_DIGIT;
            phase      = PH_ERROR;
          end
        end
        PH_REASON: begin
          if (b == ByteCr) begin
            r.kind = KIND_DELIM;
            phase  = PH_LF;
          end else if (b == ByteHt || (b >= ByteSp && b != ByteDel)) begin
            r.kind     = KIND_REASON;
            r.byte_out = b;
          end else begin
            r.kind     = KIND_ERROR;
            last_error = ERR_CTRL_CHAR;
            phase      = PH_ERROR;
          end
        end
        PH_LF: begin
          if (b == ByteLf) begin
            r.kind = KIND_LINE;
            phase  = PH_DONE;
          end else begin
            r.kind     = KIND_ERROR;
            last_error = ERR_NO_LF;
            phase      = PH_ERROR;
          end
        end
        default: ;
      endcase
      r.status_code = code_value;
      r.error_code  = last_error;
      pending_results = {pending_results, r};
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void match_result(logic [OutDataW-1:0] data, logic [KindW-1:0] kind);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result item with none outstanding: kind %0d, data %h", kind, data);
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind) report("kind", want.kind, kind);
      if (data[ByteW-1:0] !== want.byte_out)
        report("byte_out", want.byte_out, data[ByteW-1:0]);
      if (data[ByteW +: CodeW] !== want.status_code)
        report("status_code", want.status_code, data[ByteW +: CodeW]);
      if (data[ByteW+CodeW +: ErrW] !== want.error_code)
        report("error_code", want.error_code, data[ByteW+CodeW +: ErrW]);
      if (data[OutDataW-1:ByteW+CodeW+ErrW] !== '0)
        report("padding", 0, data[OutDataW-1:ByteW+CodeW+ErrW]);
    endfunction
  endclass

  status_line_tracker tracker = new;

  int tx_calm   = 0;
  int rx_calm   = 0;
  int hold_left = 0;

  logic [ByteW-1:0] proto_seed [16] = '{8'h00, 8'hFF, 8'h55, 8'hAA, ByteCr, ByteLf,
                                        ByteHt, ByteDel, "H", "T", "T", "P", "/", "1",
                                        ".", "1"};

  // Mostly no gap, often a short one, now and then a long one; calm runs have none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 299) == 0) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit plain_reason(logic [ByteW-1:0] v);
    return v == ByteHt || (v >= ByteSp && v != ByteDel && v != ByteCr);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    tracker.take_byte(b);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CodeW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    tracker.set_bound(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: check every accepted result, stall at random.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        tracker.match_result(m_axis_tdata, m_axis_tuser);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        hold_left = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    int               plan;
    int               n_digits;
    int               count;
    int               line_end;
    logic [ByteW-1:0] b;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] lo;
    logic [CodeW-1:0] hi;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgCodeMin;
    cfg_wdata_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan     = $urandom_range(0, 15);
    n_digits = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 3;
    if (plan == 0) n_digits = 0;

    write_reg(CfgCodeMin, '0);
    write_reg(CfgCodeMax, '1);
    write_reg(CfgSpare, CodeW'($urandom));

    foreach (proto_seed[i]) send_byte(proto_seed[i]);
    drain_results();
    write_reg(CfgCodeMin, 10'd999);
    write_reg(CfgCodeMax, '0);

    // runs that never reach the reason phase carry their random load here
    count = (plan >= 4) ? $urandom_range(150, 350) : $urandom_range(1300, 1500);
    repeat (count) begin
      do b = ByteW'($urandom); while (b == ByteSp);
      send_byte(b);
    end

    send_byte(ByteSp);
    repeat (n_digits) send_byte(Byte0 + ByteW'($urandom_range(0, 9)));

    case (plan)
      0: begin
        drain_results();
        write_reg(CfgCodeMin, CodeW'($urandom_range(0, 1023)));
        write_reg(CfgCodeMax, CodeW'($urandom_range(0, 1023)));
        send_byte(ByteSp);
      end
      1: begin
        do b = ByteW'($urandom);
        while ((b >= Byte0 && b <= Byte9) || b == ByteSp || b == ByteCr);
        send_byte(b);
      end
      2: begin
        send_byte(ByteCr);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(ByteLf);
        end else begin
          do b = ByteW'($urandom); while (b == ByteLf);
          send_byte(b);
        end
      end
      3: begin
        drain_results();
        code = tracker.code_value;
        // reject from above, from below, or with the bounds crossed
        if (code > 0 && $urandom_range(0, 1) == 0) begin
          lo = '0;
          hi = CodeW'($urandom_range(0, code - 1));
        end else begin
          lo = CodeW'($urandom_range(code + 1, 1023));
          hi = ($urandom_range(0, 1) == 0) ? '1 : CodeW'($urandom_range(0, lo - 1));
        end
        write_reg(CfgCodeMin, lo);
        write_reg(CfgCodeMax, hi);
        send_byte(ByteSp);
      end
      default: begin
        drain_results();
        code = tracker.code_value;
        if ($urandom_range(0, 3) == 0) begin
          lo = code;
          hi = code;
        end else begin
          lo = CodeW'($urandom_range(0, code));
          hi = CodeW'($urandom_range(code, 1023));
        end
        write_reg(CfgCodeMin, lo);
        write_reg(CfgCodeMax, hi);
        send_byte(ByteSp);

        send_byte(ByteHt);
        send_byte(ByteSp);
        send_byte(8'h7E);
        send_byte(8'h80);
        send_byte(8'hFF);
        count = $urandom_range(1000, 1300);
        for (int i = 0; i < count; i++) begin
          if (i == count / 2) begin
            drain_results();
            write_reg(CfgCodeMin, CodeW'($urandom));
            write_reg(CfgCodeMax, CodeW'($urandom));
          end
          do b = ByteW'($urandom); while (!plain_reason(b));
          send_byte(b);
        end

        line_end = $urandom_range(0, 3);
        if (line_end <= 1) begin
          send_byte(ByteCr);
          send_byte(ByteLf);
        end else if (line_end == 2) begin
          send_byte(ByteCr);
          do b = ByteW'($urandom); while (b == ByteLf);
          send_byte(b);
        end else begin
          // control character: 0..31 apart from CR and HT, or DEL
          do begin
            b = ByteW'($urandom_range(0, 32));
            if (b == ByteSp) b = ByteDel;
          end while (b == ByteCr || b == ByteHt);
          send_byte(b);
        end
      end
    endcase

    // everything from here on is reported as ignored
    repeat (40) send_byte(ByteW'($urandom));
    drain_results();
    repeat (8) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
